@@ hw/rtl/ssir_pkg.sv @@
package ssir_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic             full_res;
    logic [CNT_W-1:0] size;
  } out_t;

  // per-cell update select, driven by the control logic in the top level
  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

@@ hw/rtl/ssir_cell.sv @@
module ssir_cell (
  input  logic                     clk,
  input  logic                     order_desc,
  input  logic                     occupied,
  input  logic [ssir_pkg::KEY_W-1:0] req_key,
  input  logic [ssir_pkg::KEY_W-1:0] left_key,
  input  logic [ssir_pkg::KEY_W-1:0] right_key,
  input  ssir_pkg::cell_ctl_t      ctl,
  output logic [ssir_pkg::KEY_W-1:0] key_q,
  output logic                     prec,
  output logic                     match
);
  import ssir_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;

  // cell holds a key that comes ahead of the request key in current order
  assign prec  = occupied & (order_desc ? (key_r > req_key) : (key_r < req_key));
  assign match = occupied & (key_r == req_key);
  assign key_q = key_r;

  always_comb begin
    if (ctl.load_new) begin
      key_nxt = req_key;
    end else if (ctl.take_left) begin
      key_nxt = left_key;
    end else if (ctl.take_right) begin
      key_nxt = right_key;
    end else begin
      key_nxt = key_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

@@ hw/rtl/sorted_set_insert_remove_top.sv @@
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall  | in_data  (op, key)
// out     | out | out_valid/out_stall| out_data (ok, full_res, size)
// cfg     | in  | cfg_we            | cfg_wdata (order_descending)
//
// One request per cycle while in_stall is low: every cell compares its key against the
// request in parallel and the cells from the request's position onward shift by one place.
// Result is registered; out_valid rises in the cycle after accept.
// in_stall is high only while a result sits in the output register stalled.
// rst_n (sync) clears the count, order bit and output valid; cell keys are
// not cleared, cells at or above the count are never looked at.
module sorted_set_insert_remove_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ssir_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ssir_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);
  import ssir_pkg::*;

  logic             order_desc_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  logic [KEY_W-1:0] key_q [CAPACITY];
  logic [CAPACITY-1:0] prec_v;
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] occ_v;
  logic [CAPACITY-1:0] before_v;
  logic [CAPACITY-1:0] at_pos_v;

  logic accept;
  logic found;
  logic is_full;
  logic do_ins;
  logic do_rem;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // prefix AND: every earlier cell precedes the key
  assign before_v[0] = 1'b1;
  for (genvar i = 1; i < CAPACITY; i++) begin : g_before
    assign before_v[i] = &prec_v[i-1:0];
  end

  assign at_pos_v = before_v & ~prec_v;
  assign found    = |(at_pos_v & match_v);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign do_ins   = accept & (in_data.op == OP_INSERT) & ~found & ~is_full;
  assign do_rem   = accept & (in_data.op == OP_REMOVE) & found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;

    assign occ_v[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_key = key_q[i];
    end else begin : g_mid_l
      assign left_key = key_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = key_q[i];
    end else begin : g_mid_r
      assign right_key = key_q[i+1];
    end

    // insert opens a gap at its position; remove closes the gap from the matching cell onward
    assign ctl.load_new   = do_ins & at_pos_v[i];
    assign ctl.take_left  = do_ins & ~before_v[i];
    assign ctl.take_right = do_rem & (at_pos_v[i] | ~before_v[i]);

    ssir_cell u_cell (
      .clk        (clk),
      .order_desc (order_desc_r),
      .occupied   (occ_v[i]),
      .req_key    (in_data.key),
      .left_key   (left_key),
      .right_key  (right_key),
      .ctl        (ctl),
      .key_q      (key_q[i]),
      .prec       (prec_v[i]),
      .match      (match_v[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_desc_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_desc_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.ok       <= do_ins | do_rem;
      out_data_r.full_res <= (in_data.op == OP_INSERT) & ~found & is_full;
      out_data_r.size     <= count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/sorted_set_insert_remove_top_tb.sv @@
module sorted_set_insert_remove_top_tb;
  import ssir_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  // shadow of the sorted store
  logic [KEY_W-1:0] set_keys [CAPACITY];
  int unsigned set_count = 0;
  logic descending = 1'b0;

  out_t due_status [$];
  int errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  int unsigned pool_base = 0;

  sorted_set_insert_remove_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 7);
  end

  // scan from the front, stop at the first cell not ahead of the key
  function automatic out_t update_key_set(op_t op, logic [KEY_W-1:0] key);
    int unsigned pos;
    int unsigned i;
    bit hit;
    out_t res;
    pos = 0;
    while (pos < set_count &&
           (descending ? (set_keys[pos] > key) : (set_keys[pos] < key)))
      pos++;
    hit = (pos < set_count) && (set_keys[pos] == key);
    res = '0;
    if (op == OP_INSERT) begin
      if (!hit && set_count >= CAPACITY) begin
        res.full_res = 1'b1;
      end else if (!hit) begin
        for (i = set_count; i > pos; i--)
          set_keys[i] = set_keys[i-1];
        set_keys[pos] = key;
        set_count++;
        res.ok = 1'b1;
      end
    end else if (hit) begin
      for (i = pos; i + 1 < set_count; i++)
        set_keys[i] = set_keys[i+1];
      set_count--;
      res.ok = 1'b1;
    end
    res.size = CNT_W'(set_count);
    return res;
  endfunction

  always @(posedge clk) begin : monitor_p
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_status.size() == 0) begin
          $error("result beat with no request pending");
          errors++;
        end else begin
          want = due_status.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, out_data.ok);
            errors++;
          end
          if (out_data.full_res !== want.full_res) begin
            $error("full_res: expected %0d, actual %0d", want.full_res, out_data.full_res);
            errors++;
          end
          if (out_data.size !== want.size) begin
            $error("size: expected %0d, actual %0d", want.size, out_data.size);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        due_status.push_back(update_key_set(in_data.op, in_data.key));
      if (cfg_we)
        descending = cfg_wdata;
    end
  end

  task automatic send_request(op_t op, logic [KEY_W-1:0] key);
    in_t req;
    req.op = op;
    req.key = key;
    if (!quiet) begin
      while ($urandom_range(99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_order(logic desc);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // removing the front key always hits, whatever order the cells are in
  task automatic drain_set();
    logic [KEY_W-1:0] held [$];
    settle();
    for (int i = 0; i < set_count; i++)
      held.push_back(set_keys[i]);
    foreach (held[i])
      send_request(OP_REMOVE, held[i]);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(3) != 0)
      return KEY_W'($urandom_range(pool_base + 23, pool_base));
    return KEY_W'($urandom);
  endfunction

  task automatic run_random(int n, int insert_pct);
    op_t op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_request(op, pick_key());
    end
  endtask

  task automatic test_directed();
    send_request(OP_REMOVE, 8'd5);     // absent in empty store
    send_request(OP_INSERT, 8'd0);
    send_request(OP_INSERT, 8'd255);
    send_request(OP_INSERT, 8'd0);     // duplicate
    send_request(OP_REMOVE, 8'd255);
    for (int i = 1; i <= 15; i++)
      send_request(OP_INSERT, KEY_W'(i * 17 - 7));
    send_request(OP_INSERT, 8'd200);   // full
    send_request(OP_INSERT, 8'd0);     // duplicate beats full
    send_request(OP_REMOVE, 8'd0);
    send_request(OP_REMOVE, 8'd0);     // now absent
  endtask

  // flip order with keys held: cells keep ascending layout
  task automatic test_order_flip_held();
    set_order(1'b1);
    for (int i = 0; i < 20; i++)
      send_request(op_t'($urandom_range(1)), KEY_W'(($urandom_range(15) * 17) - 7));
    send_request(OP_INSERT, 8'd255);
    send_request(OP_INSERT, 8'd0);
    drain_set();
  endtask

  task automatic test_descending_random();
    pool_base = $urandom_range(232);
    run_random(200, 55);
  endtask

  task automatic test_ascending_back_to_back();
    set_order(1'b0);
    drain_set();
    quiet = 1'b1;
    pool_base = 232;
    run_random(200, 60);
    quiet = 1'b0;
  endtask

  task automatic test_mixed_orders();
    for (int p = 0; p < 4; p++) begin
      set_order(logic'($urandom_range(1)));
      if (p[0]) drain_set();
      pool_base = (p == 2) ? 0 : $urandom_range(232);
      run_random(120, (p == 3) ? 70 : 50);
    end
  endtask

  task automatic test_remove_heavy();
    set_order(1'b1);
    pool_base = $urandom_range(232);
    run_random(60, 80);
    run_random(60, 25);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_order_flip_held();
    test_descending_random();
    test_ascending_back_to_back();
    test_mixed_orders();
    test_remove_heavy();
    settle();
    repeat (5) @(posedge clk);
    if (errors == 0 && due_status.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
